>>> hdl/dmsa_pkg.sv
// dmsa_pkg: shared widths, limits, types and the back-end state encoding
// for the dual motor speed averager
// no dependencies
package dmsa_pkg;

  // field widths
  localparam int SAMPLE_BITS = 10;
  localparam int SUM_BITS    = 16;
  localparam int COUNT_BITS  = 8;
  localparam int IN_SMP_BITS = 10;
  localparam int SMP_USE     = (SAMPLE_BITS < IN_SMP_BITS) ? SAMPLE_BITS : IN_SMP_BITS;
  localparam int FRAC_BITS   = 8;
  localparam int AVG_BITS    = 24;

  // divider sizing
  localparam int DIV_BITS  = SUM_BITS + FRAC_BITS;
  localparam int STEP_BITS = $clog2(DIV_BITS + 1);

  // magnitude limits of the signed average
  localparam logic [DIV_BITS-1:0] NEG_LIMIT = DIV_BITS'(1) << (AVG_BITS - 1);
  localparam logic [DIV_BITS-1:0] POS_LIMIT = NEG_LIMIT - DIV_BITS'(1);

  // stream widths
  localparam int S_DATA_BITS = 16;
  localparam int M_DATA_BITS = 56;

  // snapshot queue
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = 1;
  localparam int Q_CNT_BITS = 2;

  // input kinds carried on tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // snapshot taken by a read
  typedef struct packed {
    logic [SUM_BITS-1:0]   sum_left;
    logic [SUM_BITS-1:0]   sum_right;
    logic [COUNT_BITS-1:0] cnt_left;
    logic [COUNT_BITS-1:0] cnt_right;
    logic                  wrap;
  } snap_t;

  // one channel's divider result
  typedef struct packed {
    logic [AVG_BITS-1:0] avg;
    logic                empty;
  } div_res_t;

  // divider status toward the back end
  typedef struct packed {
    logic busy;
  } div_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_st_t;

endpackage

>>> hdl/dual_motor_speed_averager.sv
// dual_motor_speed_averager: top level, front end, snapshot queue, back end
// depends on dmsa_pkg, dmsa_front, dmsa_fifo, dmsa_back
//
// Input stream: tuser 0 carries a converter sample, tuser 1 asks for the
// averages and clears the sums. Samples alternate left, right, left...
// starting with left after reset; a read does not change that order.
// A sample beat is taken every cycle unless the queue is full, and gives
// no output beat. A read beat snapshots both sums and counts into a
// two-entry queue; the back end then divides both channels at once, one
// quotient bit a cycle over SUM_BITS + 8 = 24 steps, and takes the next
// snapshot from the queue once the result beat is in the output register.
// The output beat sits in a register; while the receiver stalls, samples
// are still taken and up to two more reads queue. s_tready drops only
// when the queue is full.
// Reset clears the sums, counts and wrap flag, empties the queue and drops
// m_tvalid; s_tready is high in the cycle after reset.
module dual_motor_speed_averager (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // sample_value[9:0], left_reverse[10], right_reverse[11], zero fill
  input  logic [15:0] s_tdata,
  // action[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // left_average[23:0], right_average[47:24], left_empty[48],
  // right_empty[49], wrapped[50], zero fill
  output logic [55:0] m_tdata
);
  import dmsa_pkg::*;

  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;
  snap_t q_in;
  snap_t q_head;

  dmsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_in)
  );

  dmsa_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  dmsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (q_head),
    .q_empty  (q_empty),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // the queue cannot be full and empty at once
  a_q_flags: assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("snapshot queue full and empty together");

  // the back end never pops an empty queue
  a_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> !q_empty)
    else $error("pop from empty snapshot queue");

  // input side is open right after reset
  a_ready_after_rst: assert property (@(posedge clk) rst |=> s_tready)
    else $error("s_tready low after reset");

  // an empty channel always reads as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((!m_tdata[48] || (m_tdata[23:0] == '0)) &&
                  (!m_tdata[49] || (m_tdata[47:24] == '0))))
    else $error("empty channel with nonzero average");

endmodule

>>> hdl/dmsa_front.sv
// dmsa_front: takes input beats, accumulates samples per channel and
// snapshots-and-clears on a read; depends on dmsa_pkg
module dmsa_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dmsa_pkg::S_DATA_BITS-1:0] s_tdata,
  input  logic                           s_tuser,
  input  logic                           q_full,
  output logic                           push,
  output dmsa_pkg::snap_t                push_data
);
  import dmsa_pkg::*;

  logic                  chan_left;
  logic [SUM_BITS-1:0]   sums [2];
  logic [COUNT_BITS-1:0] counts [2];
  logic                  wrap;

  logic                  accept;
  logic                  is_read;
  logic                  ch;
  logic                  rev;
  logic [SUM_BITS:0]     smp;
  logic [SUM_BITS:0]     sum_ext;
  logic [SUM_BITS:0]     sum_next;
  logic                  sum_ovf;
  logic                  cnt_top;

  // handshake and classification
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign is_read  = (s_tuser == ACT_READ);
  assign ch       = !chan_left;
  assign rev      = chan_left ? s_tdata[10] : s_tdata[11];

  // signed accumulate with one guard bit
  assign smp      = (SUM_BITS + 1)'(s_tdata[SMP_USE-1:0]);
  assign sum_ext  = {sums[ch][SUM_BITS-1], sums[ch]};
  assign sum_next = rev ? (sum_ext - smp) : (sum_ext + smp);
  assign sum_ovf  = sum_next[SUM_BITS] != sum_next[SUM_BITS-1];
  assign cnt_top  = (counts[ch] == {COUNT_BITS{1'b1}});

  // snapshot toward the queue
  assign push = accept && is_read;
  always_comb begin
    push_data.sum_left  = sums[0];
    push_data.sum_right = sums[1];
    push_data.cnt_left  = counts[0];
    push_data.cnt_right = counts[1];
    push_data.wrap      = wrap;
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      chan_left <= 1'b1;
      sums[0]   <= '0;
      sums[1]   <= '0;
      counts[0] <= '0;
      counts[1] <= '0;
      wrap      <= 1'b0;
    end else if (accept) begin
      if (is_read) begin
        sums[0]   <= '0;
        sums[1]   <= '0;
        counts[0] <= '0;
        counts[1] <= '0;
        wrap      <= 1'b0;
      end else begin
        chan_left  <= !chan_left;
        sums[ch]   <= sum_next[SUM_BITS-1:0];
        counts[ch] <= cnt_top ? '0 : counts[ch] + COUNT_BITS'(1);
        if (sum_ovf || cnt_top) begin
          wrap <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/dmsa_fifo.sv
// dmsa_fifo: short queue of read snapshots between front and back end
// depends on dmsa_pkg
module dmsa_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dmsa_pkg::snap_t push_data,
  input  logic            pop,
  output dmsa_pkg::snap_t head,
  output logic            full,
  output logic            empty
);
  import dmsa_pkg::*;

  snap_t                 entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] fill;

  assign full  = (fill == Q_CNT_BITS'(Q_DEPTH));
  assign empty = (fill == '0);
  assign head  = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_BITS'(1);
      end
      if (push && !pop) begin
        fill <= fill + Q_CNT_BITS'(1);
      end else if (pop && !push) begin
        fill <= fill - Q_CNT_BITS'(1);
      end
    end
  end

endmodule

>>> hdl/dmsa_div.sv
// dmsa_div: restoring divider, one quotient bit a cycle, giving a signed
// average with 8 fractional bits; depends on dmsa_pkg
module dmsa_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dmsa_pkg::SUM_BITS-1:0]   sum,
  input  logic [dmsa_pkg::COUNT_BITS-1:0] count,
  output dmsa_pkg::div_stat_t            stat,
  output dmsa_pkg::div_res_t             res
);
  import dmsa_pkg::*;

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic                  neg;
  logic                  zero_cnt;
  logic [COUNT_BITS-1:0] divisor;
  logic [COUNT_BITS-1:0] rem;
  logic [DIV_BITS-1:0]   quo;

  logic [SUM_BITS-1:0]   mag;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  fits;

  // operand magnitude
  assign mag    = sum[SUM_BITS-1] ? (~sum + SUM_BITS'(1)) : sum;
  assign rem_sh = {rem, quo[DIV_BITS-1]};
  assign fits   = rem_sh >= {1'b0, divisor};

  assign stat.busy = busy;

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_BITS'(DIV_BITS);
    end else if (busy) begin
      step <= step - STEP_BITS'(1);
      if (step == STEP_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg      <= sum[SUM_BITS-1];
      zero_cnt <= (count == '0);
      divisor  <= count;
      rem      <= '0;
      quo      <= {mag, FRAC_BITS'(0)};
    end else if (busy) begin
      if (fits) begin
        rem <= COUNT_BITS'(rem_sh - {1'b0, divisor});
        quo <= {quo[DIV_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh[COUNT_BITS-1:0];
        quo <= {quo[DIV_BITS-2:0], 1'b0};
      end
    end
  end

  // sign, saturation and empty channel
  always_comb begin
    res.empty = zero_cnt;
    if (zero_cnt) begin
      res.avg = '0;
    end else if (neg) begin
      if (quo > NEG_LIMIT) begin
        res.avg = NEG_LIMIT[AVG_BITS-1:0];
      end else begin
        res.avg = ~quo[AVG_BITS-1:0] + AVG_BITS'(1);
      end
    end else begin
      if (quo > POS_LIMIT) begin
        res.avg = POS_LIMIT[AVG_BITS-1:0];
      end else begin
        res.avg = quo[AVG_BITS-1:0];
      end
    end
  end

endmodule

>>> hdl/dmsa_back.sv
// dmsa_back: pops snapshots, runs both channel divides in parallel and
// holds the result beat in an output register; depends on dmsa_pkg, dmsa_div
module dmsa_back (
  input  logic                             clk,
  input  logic                             rst,
  input  dmsa_pkg::snap_t                  head,
  input  logic                             q_empty,
  output logic                             pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [dmsa_pkg::M_DATA_BITS-1:0] m_tdata
);
  import dmsa_pkg::*;

  back_st_t  state;
  back_st_t  state_next;
  logic      start;
  logic      load;
  logic      wrap;
  div_stat_t stat_left;
  div_stat_t stat_right;
  div_res_t  res_left;
  div_res_t  res_right;

  dmsa_div u_div_left (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sum   (head.sum_left),
    .count (head.cnt_left),
    .stat  (stat_left),
    .res   (res_left)
  );

  dmsa_div u_div_right (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sum   (head.sum_right),
    .count (head.cnt_right),
    .stat  (stat_right),
    .res   (res_right)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    start      = 1'b0;
    load       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          start      = 1'b1;
          state_next = BK_DIV;
        end
      end
      BK_DIV: begin
        if (!stat_left.busy && !stat_right.busy) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign pop = start;

  // wrap flag rides along with the divide
  always_ff @(posedge clk) begin
    if (start) begin
      wrap <= head.wrap;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {5'b0, wrap, res_right.empty, res_left.empty,
                  res_right.avg, res_left.avg};
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking stream testbench for dual_motor_speed_averager
// depends on dmsa_pkg and the dual_motor_speed_averager rtl
module tb_top;
  import dmsa_pkg::*;

  localparam int TOTAL_BEATS = 1950;
  localparam int QUIET_BEATS = 250;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_GROUP_ROOM = 600;

  // one result beat, unpacked
  typedef struct packed {
    logic [AVG_BITS-1:0] left_avg;
    logic [AVG_BITS-1:0] right_avg;
    logic                left_empty;
    logic                right_empty;
    logic                wrapped;
  } avg_result_t;

  // one directed stimulus row
  typedef struct packed {
    logic                   act;
    logic [IN_SMP_BITS-1:0] smp;
    logic                   lrev;
    logic                   rrev;
    logic                   typed;
    avg_result_t            want;
  } stim_row_t;

  typedef enum int {
    GRP_SHORT,
    GRP_SUM_WRAP,
    GRP_CNT_WRAP
  } grp_kind_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  // sample_value[9:0], left_reverse[10], right_reverse[11], zero fill
  logic [S_DATA_BITS-1:0] s_tdata;
  // action[0]
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  // left_average[23:0], right_average[47:24], left_empty[48],
  // right_empty[49], wrapped[50], zero fill
  logic [M_DATA_BITS-1:0] m_tdata;

  // speed accumulator copy kept by the testbench
  logic                  next_is_left;
  logic [SUM_BITS-1:0]   speed_sum [2];
  logic [COUNT_BITS-1:0] speed_cnt [2];
  logic                  wrap_flag;

  avg_result_t pending_averages[$];
  stim_row_t   directed_rows[$];
  int          error_count;
  int          beats_sent;
  bit          quiet;
  int          idle_cycles;

  dual_motor_speed_averager dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // add or subtract one sample on the current channel
  function automatic void accumulate_speed(logic [IN_SMP_BITS-1:0] smp, logic lrev, logic rrev);
    int     ch;
    logic   rev;
    longint val;
    longint s;
    longint hi;
    ch  = next_is_left ? 0 : 1;
    rev = next_is_left ? lrev : rrev;
    val = longint'(smp) & ((64'sd1 <<< SMP_USE) - 1);
    hi  = (64'sd1 <<< (SUM_BITS - 1)) - 1;
    s   = longint'($signed(speed_sum[ch]));
    s   = rev ? s - val : s + val;
    if (s > hi || s < -hi - 1) wrap_flag = 1'b1;
    speed_sum[ch] = s[SUM_BITS-1:0];
    if (speed_cnt[ch] == {COUNT_BITS{1'b1}}) begin
      speed_cnt[ch] = '0;
      wrap_flag = 1'b1;
    end else begin
      speed_cnt[ch] = speed_cnt[ch] + 1'b1;
    end
    next_is_left = ~next_is_left;
  endfunction

  // fixed point mean, truncated toward zero, saturated to the output range
  function automatic logic [AVG_BITS-1:0] mean_fixed(logic [SUM_BITS-1:0] sum,
                                                      logic [COUNT_BITS-1:0] cnt);
    longint q;
    longint amax;
    if (cnt == '0) return '0;
    amax = (64'sd1 <<< (AVG_BITS - 1)) - 1;
    q = (longint'($signed(sum)) * (64'sd1 <<< FRAC_BITS)) / longint'(cnt);
    if (q > amax) q = amax;
    if (q < -amax - 1) q = -amax - 1;
    return q[AVG_BITS-1:0];
  endfunction

  // snapshot both channels and clear
  function automatic avg_result_t take_averages();
    avg_result_t r;
    r.left_avg    = mean_fixed(speed_sum[0], speed_cnt[0]);
    r.right_avg   = mean_fixed(speed_sum[1], speed_cnt[1]);
    r.left_empty  = (speed_cnt[0] == '0);
    r.right_empty = (speed_cnt[1] == '0);
    r.wrapped     = wrap_flag;
    speed_sum[0]  = '0;
    speed_sum[1]  = '0;
    speed_cnt[0]  = '0;
    speed_cnt[1]  = '0;
    wrap_flag     = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t row(logic act, int smp, logic lrev, logic rrev, logic typed,
                                    int la, int ra, logic le, logic re, logic wr);
    stim_row_t r;
    r.act              = act;
    r.smp              = smp[IN_SMP_BITS-1:0];
    r.lrev             = lrev;
    r.rrev             = rrev;
    r.typed            = typed;
    r.want.left_avg    = la[AVG_BITS-1:0];
    r.want.right_avg   = ra[AVG_BITS-1:0];
    r.want.left_empty  = le;
    r.want.right_empty = re;
    r.want.wrapped     = wr;
    return r;
  endfunction

  // drive one input beat, optionally after a gap, and predict on acceptance
  task automatic send_beat(logic act, logic [IN_SMP_BITS-1:0] smp, logic lrev, logic rrev,
                           logic typed, avg_result_t want);
    int          gap;
    avg_result_t got;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 15);
      repeat (gap) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= S_DATA_BITS'({rrev, lrev, smp});
    do @(posedge clk); while (!s_tready);
    if (act == ACT_READ) begin
      got = take_averages();
      pending_averages.push_back(typed ? want : got);
    end else begin
      accumulate_speed(smp, lrev, rrev);
    end
    beats_sent++;
    if (beats_sent >= TOTAL_BEATS - QUIET_BEATS) quiet = 1'b1;
  endtask

  // result checker
  always @(posedge clk) begin
    avg_result_t got;
    avg_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got.left_avg    = m_tdata[23:0];
      got.right_avg   = m_tdata[47:24];
      got.left_empty  = m_tdata[48];
      got.right_empty = m_tdata[49];
      got.wrapped     = m_tdata[50];
      if (pending_averages.size() == 0) begin
        flag_error($sformatf("result beat with nothing pending, tdata %h", m_tdata));
      end else begin
        exp_r = pending_averages.pop_front();
        if (got.left_avg !== exp_r.left_avg)
          flag_error($sformatf("left_average got %0d want %0d",
                               $signed(got.left_avg), $signed(exp_r.left_avg)));
        if (got.right_avg !== exp_r.right_avg)
          flag_error($sformatf("right_average got %0d want %0d",
                               $signed(got.right_avg), $signed(exp_r.right_avg)));
        if (got.left_empty !== exp_r.left_empty)
          flag_error($sformatf("left_empty got %b want %b", got.left_empty, exp_r.left_empty));
        if (got.right_empty !== exp_r.right_empty)
          flag_error($sformatf("right_empty got %b want %b",
                               got.right_empty, exp_r.right_empty));
        if (got.wrapped !== exp_r.wrapped)
          flag_error($sformatf("wrapped got %b want %b", got.wrapped, exp_r.wrapped));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver stalls in bursts, always ready near the end
  initial begin
    int   hold;
    logic lvl;
    hold = 0;
    lvl  = 1'b1;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        m_tready <= 1'b1;
      end else begin
        if (hold == 0) begin
          if ($urandom_range(0, 5) == 0) begin
            lvl  = 1'b0;
            hold = $urandom_range(1, 15);
          end else begin
            lvl  = 1'b1;
            hold = $urandom_range(1, 30);
          end
        end
        hold--;
        m_tready <= lvl;
      end
    end
  end

  // main stimulus
  initial begin
    avg_result_t blank;
    stim_row_t   r;
    grp_kind_t   kind;
    bit          first_group;
    int          n;
    int          pick;
    logic        dir_l;
    logic        dir_r;
    logic [IN_SMP_BITS-1:0] smp;

    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tuser      = ACT_SAMPLE;
    s_tdata      = '0;
    beats_sent   = 0;
    quiet        = 1'b0;
    blank        = '0;
    next_is_left = 1'b1;
    speed_sum[0] = '0;
    speed_sum[1] = '0;
    speed_cnt[0] = '0;
    speed_cnt[1] = '0;
    wrap_flag    = 1'b0;

    // directed rows: reset read, extremes, empty channels, order kept across reads
    directed_rows.push_back(row(ACT_READ,   0,    0, 0, 1, 0, 0, 1, 1, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1023, 0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1023, 0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_READ,   0,    0, 0, 1, 261888, -261888, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 0,    1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_READ,   1023, 1, 1, 1, 0, 0, 0, 1, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1,    1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 512,  1, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 3,    0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_READ,   0,    0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 5,    0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_READ,   0,    0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 7,    0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 0,    0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 341,  0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 682,  0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1,    0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_READ,   0,    0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_READ,   0,    0, 0, 1, 0, 0, 1, 1, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1,    0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1000, 0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 1,    1, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 10,   0, 0, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_SAMPLE, 0,    0, 1, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(row(ACT_READ,   0,    0, 0, 0, 0, 0, 0, 0, 0));

    // reset
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_beat(r.act, r.smp, r.lrev, r.rrev, r.typed, r.want);
    end

    // random groups of samples closed by a read
    first_group = 1'b1;
    while (beats_sent < TOTAL_BEATS) begin
      pick = $urandom_range(0, 99);
      if (first_group) kind = GRP_CNT_WRAP;
      else if (pick < 2 && TOTAL_BEATS - beats_sent > LONG_GROUP_ROOM) kind = GRP_CNT_WRAP;
      else if (pick < 15) kind = GRP_SUM_WRAP;
      else kind = GRP_SHORT;
      first_group = 1'b0;
      dir_l = 1'($urandom_range(0, 1));
      dir_r = 1'($urandom_range(0, 1));
      case (kind)
        GRP_CNT_WRAP: n = $urandom_range(511, 514);
        GRP_SUM_WRAP: n = $urandom_range(60, 90);
        default:      n = $urandom_range(0, 30);
      endcase
      for (int k = 0; k < n; k++) begin
        case (kind)
          GRP_CNT_WRAP: begin
            smp = IN_SMP_BITS'($urandom_range(0, 63));
            send_beat(ACT_SAMPLE, smp, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, blank);
          end
          GRP_SUM_WRAP: begin
            smp = IN_SMP_BITS'($urandom_range(900, 1023));
            send_beat(ACT_SAMPLE, smp, dir_l, dir_r, 1'b0, blank);
          end
          default: begin
            smp = IN_SMP_BITS'($urandom);
            send_beat(ACT_SAMPLE, smp, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'b0, blank);
          end
        endcase
      end
      smp = IN_SMP_BITS'($urandom);
      send_beat(ACT_READ, smp, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'b0, blank);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain outstanding results
    while (pending_averages.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/dmsa_pkg.sv
hdl/dmsa_front.sv
hdl/dmsa_fifo.sv
hdl/dmsa_div.sv
hdl/dmsa_back.sv
hdl/dual_motor_speed_averager.sv
dv/tb_top.sv
